// ===== sv/trpm_pkg.sv =====
// ----------------------------------------------------------------------------
// trpm_pkg: shared types and constants of the traffic rate peak meter
// Sizes of the counter, delta and rescale datapaths, the sequencer states
// and the control bundles passed between the top level and its units.
// ----------------------------------------------------------------------------
package trpm_pkg;

    // Port field widths (fixed by the interface)
    localparam int COUNT_FIELD_W   = 64;
    localparam int DELTA_FIELD_W   = 32;
    localparam int RESCALE_FIELD_W = 16;
    localparam int PCT_W           = 7;

    // Datapath sizes
    localparam int COUNTER_BITS      = 64;   // 33..64
    localparam int DELTA_BITS        = 32;   // 8..32
    localparam int RESCALE_FRAC_BITS = 16;   // 8..24

    // Bit counter of the serial subtract pass
    localparam int BIT_CNT_W = $clog2(COUNTER_BITS);
    localparam logic [BIT_CNT_W-1:0] BIT_LAST      = BIT_CNT_W'(COUNTER_BITS - 1);
    localparam logic [BIT_CNT_W-1:0] BIT_DELTA_END = BIT_CNT_W'(DELTA_BITS);

    // Divider step counter
    localparam int DIV_CNT_W = $clog2(RESCALE_FRAC_BITS + 1);

    // 100 * delta
    localparam int PROD_W = DELTA_BITS + PCT_W;

    // Direction codes
    localparam logic DIR_RX = 1'b0;
    localparam logic DIR_TX = 1'b1;

    // Transaction kinds
    localparam logic KIND_BASELINE = 1'b0;
    localparam logic KIND_MEASURE  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUB,
        ST_CMP,
        ST_RSC_GO,
        ST_RSC_WAIT,
        ST_PCT_CHK,
        ST_MUL_HI,
        ST_MUL_LO,
        ST_PCT_GO,
        ST_PCT_WAIT,
        ST_DONE
    } state_t;

    // Control of one serial subtractor
    typedef struct packed {
        logic load_base;   // baseline takes the snapshot at once
        logic load_snap;   // snapshot register loads, borrow clears
        logic shift;       // one bit of the subtract pass
        logic keep_low;    // difference bit lies in the delta window
    } sub_ctrl_t;

    // Request to the divider
    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] steps;
    } div_req_t;

endpackage

// ===== sv/trpm_serial_sub.sv =====
// ----------------------------------------------------------------------------
// trpm_serial_sub: bit-serial counter delta for one direction
// Holds the baseline; subtracts it from a snapshot one bit per cycle, LSB
// first, and shifts the snapshot into the baseline on the way.
// ----------------------------------------------------------------------------
module trpm_serial_sub (
    input  logic                             clk,
    input  logic                             rst_n,
    input  trpm_pkg::sub_ctrl_t              ctrl,
    input  logic [trpm_pkg::COUNTER_BITS-1:0] count,
    output logic [trpm_pkg::DELTA_BITS-1:0]   delta
);
    import trpm_pkg::*;

    logic [COUNTER_BITS-1:0] base_reg, base_next;
    logic [COUNTER_BITS-1:0] snap_reg, snap_next;
    logic [DELTA_BITS-1:0]   diff_reg, diff_next;
    logic                    borrow_reg, borrow_next;
    logic                    a_bit, b_bit, d_bit;

    assign a_bit = snap_reg[0];
    assign b_bit = base_reg[0];
    assign d_bit = a_bit ^ b_bit ^ borrow_reg;

    always_comb
    begin
        base_next   = base_reg;
        snap_next   = snap_reg;
        diff_next   = diff_reg;
        borrow_next = borrow_reg;
        if (ctrl.load_base)
        begin
            base_next = count;
        end
        if (ctrl.load_snap)
        begin
            snap_next   = count;
            borrow_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            base_next   = {a_bit, base_reg[COUNTER_BITS-1:1]};
            snap_next   = {1'b0, snap_reg[COUNTER_BITS-1:1]};
            borrow_next = (~a_bit & b_bit) | (~(a_bit ^ b_bit) & borrow_reg);
            if (ctrl.keep_low)
            begin
                diff_next = {d_bit, diff_reg[DELTA_BITS-1:1]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= '0;
            borrow_reg <= 1'b0;
        end
        else
        begin
            base_reg   <= base_next;
            borrow_reg <= borrow_next;
        end
    end

    always_ff @(posedge clk)
    begin
        snap_reg <= snap_next;
        diff_reg <= diff_next;
    end

    // Counter went backwards: no traffic
    assign delta = borrow_reg ? '0 : diff_reg;

endmodule

// ===== sv/trpm_divider.sv =====
// ----------------------------------------------------------------------------
// trpm_divider: restoring divider, one quotient bit per cycle
// Partial remainder starts below the divisor; low dividend bits shift in
// MSB first. Quotient holds up to RESCALE_FRAC_BITS bits.
// ----------------------------------------------------------------------------
module trpm_divider (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  trpm_pkg::div_req_t                    req,
    input  logic [trpm_pkg::DELTA_BITS-1:0]        rem_init,
    input  logic [trpm_pkg::RESCALE_FRAC_BITS-1:0] low_init,
    input  logic [trpm_pkg::DELTA_BITS-1:0]        divisor,
    output logic                                  busy,
    output logic [trpm_pkg::RESCALE_FRAC_BITS-1:0] quotient
);
    import trpm_pkg::*;

    logic [DELTA_BITS-1:0]        rem_reg;
    logic [DELTA_BITS-1:0]        dvs_reg;
    logic [RESCALE_FRAC_BITS-1:0] low_reg;
    logic [RESCALE_FRAC_BITS-1:0] quo_reg;
    logic [DIV_CNT_W-1:0]         cnt_reg;
    logic [DELTA_BITS:0]          trial;
    logic [DELTA_BITS:0]          trial_sub;
    logic                         fits;

    assign trial     = {rem_reg, low_reg[RESCALE_FRAC_BITS-1]};
    assign trial_sub = trial - {1'b0, dvs_reg};
    assign fits      = (trial >= {1'b0, dvs_reg});
    assign busy      = (cnt_reg != '0);
    assign quotient  = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (req.start)
        begin
            cnt_reg <= req.steps;
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= rem_init;
            low_reg <= low_init;
            dvs_reg <= divisor;
            quo_reg <= '0;
        end
        else if (busy)
        begin
            rem_reg <= fits ? trial_sub[DELTA_BITS-1:0] : trial[DELTA_BITS-1:0];
            low_reg <= {low_reg[RESCALE_FRAC_BITS-2:0], 1'b0};
            quo_reg <= {quo_reg[RESCALE_FRAC_BITS-2:0], fits};
        end
    end

endmodule

// ===== sv/traffic_rate_peak_meter.sv =====
// ----------------------------------------------------------------------------
// traffic_rate_peak_meter: byte counter interval and peak tracker
// Measures received/sent traffic per interval against a stored baseline,
// keeps the peak per direction and reports percent of peak and rescale.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid / in_stall): one transaction per counter snapshot.
//   kind = 0 stores the snapshot as baseline, kind = 1 measures against it.
//   query_ok = 0 marks a failed query: the result is all zeros, no state moves.
//   Output channel (out_valid / out_stall): exactly one result per input.
// Sequence
//   Baseline and failed transactions go straight to the final state.
//   Measure transactions: a bit-serial subtract pass (both directions in
//   parallel), then each direction uses the shared one-bit-per-cycle divider:
//   a rescale when the peak rises, then the percent when the peak is not
//   zero. One transaction is in flight at a time; in_stall is high while it
//   is being worked on.
// Reset
//   Baselines and peaks clear to zero, the output register empties.
// Stalls
//   A finished result sits in the output register while out_stall is high;
//   the next transaction is still accepted and waits in its final state
//   until the output register frees up.
// ----------------------------------------------------------------------------
module traffic_rate_peak_meter (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 kind,
    input  logic                                 query_ok,
    input  logic [trpm_pkg::COUNT_FIELD_W-1:0]   received_count,
    input  logic [trpm_pkg::COUNT_FIELD_W-1:0]   sent_count,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [trpm_pkg::PCT_W-1:0]           download_percent,
    output logic [trpm_pkg::PCT_W-1:0]           upload_percent,
    output logic [trpm_pkg::DELTA_FIELD_W-1:0]   download_delta,
    output logic [trpm_pkg::DELTA_FIELD_W-1:0]   upload_delta,
    output logic [trpm_pkg::RESCALE_FIELD_W-1:0] download_rescale,
    output logic                                 download_rescale_valid,
    output logic [trpm_pkg::RESCALE_FIELD_W-1:0] upload_rescale,
    output logic                                 upload_rescale_valid,
    output logic                                 redraw
);
    import trpm_pkg::*;

    // Sequencer
    state_t state_reg, state_next;

    logic                   in_take;
    logic                   is_measure;
    sub_ctrl_t              sub_ctrl;
    div_req_t               div_req;
    logic                   div_pct;
    logic                   rsc_load;
    logic                   pct_load;
    logic                   mul_hi;
    logic                   mul_lo;
    logic                   adv_dir;
    logic                   out_load;
    logic                   out_free;

    // Working state
    logic [BIT_CNT_W-1:0]   bit_cnt_reg;
    logic                   meas_reg;
    logic                   dir_reg;
    logic [DELTA_BITS-1:0]  peak_rx_reg, peak_tx_reg;
    logic [PCT_W-1:0]       pct_rx_reg, pct_tx_reg;
    logic [RESCALE_FRAC_BITS-1:0] rsc_rx_reg, rsc_tx_reg;
    logic                   rv_rx_reg, rv_tx_reg;
    logic [PROD_W-1:0]      mul_reg;
    logic [PROD_W-1:0]      delta_ext;

    // Output register
    logic                   out_valid_reg;
    logic [PCT_W-1:0]       out_pct_rx_reg, out_pct_tx_reg;
    logic [DELTA_FIELD_W-1:0]   out_dlt_rx_reg, out_dlt_tx_reg;
    logic [RESCALE_FIELD_W-1:0] out_rsc_rx_reg, out_rsc_tx_reg;
    logic                   out_rv_rx_reg, out_rv_tx_reg;

    // Datapath links
    logic [DELTA_BITS-1:0]  rx_delta, tx_delta;
    logic [DELTA_BITS-1:0]  cur_delta, cur_peak;
    logic [DELTA_BITS-1:0]  div_rem_init, div_divisor;
    logic [RESCALE_FRAC_BITS-1:0] div_low_init;
    logic [RESCALE_FRAC_BITS-1:0] div_quo;
    logic                   div_busy;

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_take    = in_valid && !in_stall;
    assign is_measure = query_ok && (kind == KIND_MEASURE);
    assign out_free   = !out_valid_reg || !out_stall;

    assign cur_delta = (dir_reg == DIR_TX) ? tx_delta : rx_delta;
    assign cur_peak  = (dir_reg == DIR_TX) ? peak_tx_reg : peak_rx_reg;
    assign delta_ext = PROD_W'(cur_delta);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = is_measure ? ST_SUB : ST_DONE;
                end
            end
            ST_SUB:
            begin
                if (bit_cnt_reg == BIT_LAST)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = (cur_delta > cur_peak) ? ST_RSC_GO : ST_PCT_CHK;
            end
            ST_RSC_GO:
            begin
                state_next = ST_RSC_WAIT;
            end
            ST_RSC_WAIT:
            begin
                if (!div_busy)
                begin
                    state_next = ST_PCT_CHK;
                end
            end
            ST_PCT_CHK:
            begin
                if (cur_peak != '0)
                begin
                    state_next = ST_MUL_HI;
                end
                else
                begin
                    state_next = (dir_reg == DIR_RX) ? ST_CMP : ST_DONE;
                end
            end
            ST_MUL_HI:
            begin
                state_next = ST_MUL_LO;
            end
            ST_MUL_LO:
            begin
                state_next = ST_PCT_GO;
            end
            ST_PCT_GO:
            begin
                state_next = ST_PCT_WAIT;
            end
            ST_PCT_WAIT:
            begin
                if (!div_busy)
                begin
                    state_next = (dir_reg == DIR_RX) ? ST_CMP : ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        sub_ctrl     = '0;
        div_req      = '0;
        div_pct      = 1'b0;
        rsc_load     = 1'b0;
        pct_load     = 1'b0;
        mul_hi       = 1'b0;
        mul_lo       = 1'b0;
        adv_dir      = 1'b0;
        out_load     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                sub_ctrl.load_base = in_take && query_ok && (kind == KIND_BASELINE);
                sub_ctrl.load_snap = in_take && is_measure;
            end
            ST_SUB:
            begin
                sub_ctrl.shift    = 1'b1;
                sub_ctrl.keep_low = (bit_cnt_reg < BIT_DELTA_END);
            end
            ST_RSC_GO:
            begin
                div_req.start = 1'b1;
                div_req.steps = DIV_CNT_W'(RESCALE_FRAC_BITS);
            end
            ST_RSC_WAIT:
            begin
                rsc_load = !div_busy;
            end
            ST_PCT_CHK:
            begin
                adv_dir = (cur_peak == '0) && (dir_reg == DIR_RX);
            end
            ST_MUL_HI:
            begin
                mul_hi = 1'b1;
            end
            ST_MUL_LO:
            begin
                mul_lo = 1'b1;
            end
            ST_PCT_GO:
            begin
                div_pct       = 1'b1;
                div_req.start = 1'b1;
                div_req.steps = DIV_CNT_W'(PCT_W);
            end
            ST_PCT_WAIT:
            begin
                pct_load = !div_busy;
                adv_dir  = !div_busy && (dir_reg == DIR_RX);
            end
            ST_DONE:
            begin
                out_load = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Serial subtract: one unit per direction, shared bit counter
    // ------------------------------------------------------------------
    trpm_serial_sub u_sub_rx (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (sub_ctrl),
        .count (received_count[COUNTER_BITS-1:0]),
        .delta (rx_delta)
    );

    trpm_serial_sub u_sub_tx (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (sub_ctrl),
        .count (sent_count[COUNTER_BITS-1:0]),
        .delta (tx_delta)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_cnt_reg <= '0;
        end
        else if (in_take)
        begin
            bit_cnt_reg <= '0;
        end
        else if (sub_ctrl.shift)
        begin
            bit_cnt_reg <= bit_cnt_reg + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Shared divider
    //   rescale: (old_peak << RESCALE_FRAC_BITS) / delta, old_peak < delta
    //   percent: (100 * delta) / peak, delta <= peak so quotient fits 7 bits
    // ------------------------------------------------------------------
    always_comb
    begin
        if (div_pct)
        begin
            div_rem_init = mul_reg[PROD_W-1:PCT_W];
            div_low_init = {mul_reg[PCT_W-1:0], {(RESCALE_FRAC_BITS-PCT_W){1'b0}}};
            div_divisor  = cur_peak;
        end
        else
        begin
            div_rem_init = cur_peak;
            div_low_init = '0;
            div_divisor  = cur_delta;
        end
    end

    trpm_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .rem_init (div_rem_init),
        .low_init (div_low_init),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // 100 * delta = 64 * delta + 32 * delta + 4 * delta, in two steps (ST_MUL_HI, ST_MUL_LO)
    always_ff @(posedge clk)
    begin
        if (mul_hi)
        begin
            mul_reg <= (delta_ext << 6) + (delta_ext << 5);
        end
        else if (mul_lo)
        begin
            mul_reg <= mul_reg + (delta_ext << 2);
        end
    end

    // ------------------------------------------------------------------
    // Peaks and per-transaction results
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_rx_reg <= '0;
            peak_tx_reg <= '0;
            meas_reg    <= 1'b0;
            dir_reg     <= DIR_RX;
            rv_rx_reg   <= 1'b0;
            rv_tx_reg   <= 1'b0;
        end
        else if (in_take)
        begin
            meas_reg  <= is_measure;
            dir_reg   <= DIR_RX;
            rv_rx_reg <= 1'b0;
            rv_tx_reg <= 1'b0;
        end
        else
        begin
            if (rsc_load)
            begin
                if (dir_reg == DIR_TX)
                begin
                    peak_tx_reg <= cur_delta;
                    rv_tx_reg   <= 1'b1;
                end
                else
                begin
                    peak_rx_reg <= cur_delta;
                    rv_rx_reg   <= 1'b1;
                end
            end
            if (adv_dir)
            begin
                dir_reg <= DIR_TX;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            pct_rx_reg <= '0;
            pct_tx_reg <= '0;
            rsc_rx_reg <= '0;
            rsc_tx_reg <= '0;
        end
        else
        begin
            if (rsc_load)
            begin
                if (dir_reg == DIR_TX)
                begin
                    rsc_tx_reg <= div_quo;
                end
                else
                begin
                    rsc_rx_reg <= div_quo;
                end
            end
            if (pct_load)
            begin
                if (dir_reg == DIR_TX)
                begin
                    pct_tx_reg <= div_quo[PCT_W-1:0];
                end
                else
                begin
                    pct_rx_reg <= div_quo[PCT_W-1:0];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_pct_rx_reg <= pct_rx_reg;
            out_pct_tx_reg <= pct_tx_reg;
            out_dlt_rx_reg <= meas_reg ? DELTA_FIELD_W'(rx_delta) : '0;
            out_dlt_tx_reg <= meas_reg ? DELTA_FIELD_W'(tx_delta) : '0;
            out_rsc_rx_reg <= RESCALE_FIELD_W'(rsc_rx_reg);
            out_rsc_tx_reg <= RESCALE_FIELD_W'(rsc_tx_reg);
            out_rv_rx_reg  <= rv_rx_reg;
            out_rv_tx_reg  <= rv_tx_reg;
        end
    end

    assign out_valid              = out_valid_reg;
    assign download_percent       = out_pct_rx_reg;
    assign upload_percent         = out_pct_tx_reg;
    assign download_delta         = out_dlt_rx_reg;
    assign upload_delta           = out_dlt_tx_reg;
    assign download_rescale       = out_rsc_rx_reg;
    assign download_rescale_valid = out_rv_rx_reg;
    assign upload_rescale         = out_rsc_tx_reg;
    assign upload_rescale_valid   = out_rv_tx_reg;
    assign redraw                 = out_rv_rx_reg | out_rv_tx_reg;

endmodule

// ===== sv/trpm_checker.sv =====
// ----------------------------------------------------------------------------
// trpm_checker: port-level checks of the traffic rate peak meter
// Watches the handshakes and the result fields over time.
// ----------------------------------------------------------------------------
module trpm_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_stall,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic [trpm_pkg::PCT_W-1:0]           download_percent,
    input logic [trpm_pkg::PCT_W-1:0]           upload_percent,
    input logic [trpm_pkg::RESCALE_FIELD_W-1:0] download_rescale,
    input logic                                 download_rescale_valid,
    input logic [trpm_pkg::RESCALE_FIELD_W-1:0] upload_rescale,
    input logic                                 upload_rescale_valid,
    input logic                                 redraw
);
    import trpm_pkg::*;

    // One transaction in flight: the input stalls right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted while a transaction is in flight");

    // A stalled result stays presented
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result dropped under stall");

    // Redraw is raised exactly when a peak rose
    a_redraw: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (redraw == (download_rescale_valid || upload_rescale_valid)))
        else $error("redraw disagrees with rescale flags");

    // Percent of peak never exceeds 100
    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((download_percent <= PCT_W'(100)) && (upload_percent <= PCT_W'(100))))
        else $error("percent of peak out of range");

    // No rescale factor without a peak rise
    a_rsc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((download_rescale_valid || (download_rescale == '0))
                    && (upload_rescale_valid || (upload_rescale == '0))))
        else $error("rescale factor without a peak rise");

endmodule

bind traffic_rate_peak_meter trpm_checker u_trpm_checker (.*);

// ===== test/traffic_rate_peak_meter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// traffic_rate_peak_meter_tb: self-checking bench for the traffic peak meter
// A directed table followed by a long run of random counter snapshots. Every
// result is checked field by field against a hand-written row or an in-bench model of
// the baselines and peaks, under several phases of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module traffic_rate_peak_meter_tb;
    import trpm_pkg::*;

    localparam logic QUERY_FAILED = 1'b0;
    localparam logic QUERY_OK     = 1'b1;

    localparam int RANDOM_ITEMS = 1430;
    localparam int HOLD_CYCLES  = 400;    // long receiver hold-off, fills the block
    localparam int DRAIN_CYCLES = 200;    // settle time after the last result

    localparam logic [COUNT_FIELD_W-1:0] ALL_ONES = '1;

    // One result transaction, fields in port order
    typedef struct packed {
        logic [PCT_W-1:0]           download_percent;
        logic [PCT_W-1:0]           upload_percent;
        logic [DELTA_FIELD_W-1:0]   download_delta;
        logic [DELTA_FIELD_W-1:0]   upload_delta;
        logic [RESCALE_FIELD_W-1:0] download_rescale;
        logic                       download_rescale_valid;
        logic [RESCALE_FIELD_W-1:0] upload_rescale;
        logic                       upload_rescale_valid;
        logic                       redraw;
    } meter_result_t;

    // Row of the directed table; fixed_want marks a hand-written expectation
    typedef struct packed {
        logic                     kind;
        logic                     ok;
        logic [COUNT_FIELD_W-1:0] rx;
        logic [COUNT_FIELD_W-1:0] tx;
        logic                     fixed_want;
        meter_result_t            want;
    } snapshot_row_t;

    // Per-direction outcome of the peak tracker
    typedef struct packed {
        logic [PCT_W-1:0]           pct;
        logic [RESCALE_FIELD_W-1:0] rescale;
        logic                       rose;
    } direction_view_t;

    localparam meter_result_t ALL_ZERO = '0;
    // First rise after reset: both peaks rise from zero, rescale 0, 100 %
    localparam meter_result_t FIRST_RISE = '{7'd100, 7'd100, 32'd1000, 32'd50,
                                             16'd0, 1'b1, 16'd0, 1'b1, 1'b1};

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic kind;
    logic query_ok;
    logic [COUNT_FIELD_W-1:0] received_count;
    logic [COUNT_FIELD_W-1:0] sent_count;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [PCT_W-1:0]           download_percent;
    logic [PCT_W-1:0]           upload_percent;
    logic [DELTA_FIELD_W-1:0]   download_delta;
    logic [DELTA_FIELD_W-1:0]   upload_delta;
    logic [RESCALE_FIELD_W-1:0] download_rescale;
    logic                       download_rescale_valid;
    logic [RESCALE_FIELD_W-1:0] upload_rescale;
    logic                       upload_rescale_valid;
    logic                       redraw;

    // Model state: baselines and peaks, indexed by direction
    logic [COUNT_FIELD_W-1:0] base_count [2];
    logic [DELTA_FIELD_W-1:0] peak_bytes [2];

    meter_result_t expected_readings [$];
    int mismatch_count = 0;

    // Idle control; the stall process owns hold_served and hold_left
    int gap_pct       = 0;
    int stall_pct     = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    traffic_rate_peak_meter DUT (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .in_valid               (in_valid),
        .in_stall               (in_stall),
        .kind                   (kind),
        .query_ok               (query_ok),
        .received_count         (received_count),
        .sent_count             (sent_count),
        .out_valid              (out_valid),
        .out_stall              (out_stall),
        .download_percent       (download_percent),
        .upload_percent         (upload_percent),
        .download_delta         (download_delta),
        .upload_delta           (upload_delta),
        .download_rescale       (download_rescale),
        .download_rescale_valid (download_rescale_valid),
        .upload_rescale         (upload_rescale),
        .upload_rescale_valid   (upload_rescale_valid),
        .redraw                 (redraw)
    );

    // 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Model of the meter
    // ------------------------------------------------------------------------

    // Bytes moved since the baseline; a counter that went backwards reads 0,
    // otherwise only the low DELTA_BITS of the difference survive.
    function automatic logic [DELTA_FIELD_W-1:0] interval_bytes(
        logic [COUNT_FIELD_W-1:0] now,
        logic [COUNT_FIELD_W-1:0] base
    );
        logic [63:0] window;
        window = ALL_ONES >> (64 - DELTA_BITS);
        if (now < base)
            return '0;
        return DELTA_FIELD_W'((now - base) & window);
    endfunction

    // Raises the peak of one direction when exceeded (rescale = old/new in
    // Q0.RESCALE_FRAC_BITS), then gives the percent of the current peak.
    function automatic direction_view_t track_peak_of(
        int                       dir,
        logic [DELTA_FIELD_W-1:0] delta
    );
        direction_view_t view;
        logic [63:0]     ratio;
        view = '0;
        if (delta > peak_bytes[dir])
        begin
            ratio = (64'(peak_bytes[dir]) << RESCALE_FRAC_BITS) / 64'(delta);
            view.rescale = RESCALE_FIELD_W'(ratio & ((64'd1 << RESCALE_FRAC_BITS) - 1));
            view.rose = 1'b1;
            peak_bytes[dir] = delta;
        end
        if (peak_bytes[dir] != '0)
            view.pct = PCT_W'((64'd100 * 64'(delta)) / 64'(peak_bytes[dir]));
        return view;
    endfunction

    // Applies one accepted snapshot to the model and returns its result.
    function automatic meter_result_t meter_snapshot(
        logic                     kind_in,
        logic                     ok_in,
        logic [COUNT_FIELD_W-1:0] rx,
        logic [COUNT_FIELD_W-1:0] tx
    );
        meter_result_t            res;
        direction_view_t          dn;
        direction_view_t          up;
        logic [63:0]              cmask;
        logic [DELTA_FIELD_W-1:0] rxd;
        logic [DELTA_FIELD_W-1:0] txd;
        res = '0;
        cmask = ALL_ONES >> (64 - COUNTER_BITS);
        rx = rx & cmask;
        tx = tx & cmask;
        // failed query: zeros, nothing moves
        if (ok_in == QUERY_FAILED)
            return res;
        if (kind_in == KIND_BASELINE)
        begin
            base_count[DIR_RX] = rx;
            base_count[DIR_TX] = tx;
            return res;
        end
        rxd = interval_bytes(rx, base_count[DIR_RX]);
        txd = interval_bytes(tx, base_count[DIR_TX]);
        base_count[DIR_RX] = rx;
        base_count[DIR_TX] = tx;
        up = track_peak_of(DIR_TX, txd);
        dn = track_peak_of(DIR_RX, rxd);
        res.download_percent       = dn.pct;
        res.upload_percent         = up.pct;
        res.download_delta         = rxd;    // Q22.10 kB is the raw byte count
        res.upload_delta           = txd;
        res.download_rescale       = dn.rescale;
        res.download_rescale_valid = dn.rose;
        res.upload_rescale         = up.rescale;
        res.upload_rescale_valid   = up.rose;
        res.redraw                 = dn.rose | up.rose;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Input side: gaps are drawn before valid rises, so valid never follows
    // stall, and the payload holds until the transaction is taken.
    // ------------------------------------------------------------------------
    task automatic offer_snapshot(snapshot_row_t row);
        meter_result_t predicted;
        @(negedge clk);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        kind           <= row.kind;
        query_ok       <= row.ok;
        received_count <= row.rx;
        sent_count     <= row.tx;
        in_valid       <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        // model runs on every transaction so its state tracks the block
        predicted = meter_snapshot(row.kind, row.ok, row.rx, row.tx);
        expected_readings.push_back(row.fixed_want ? row.want : predicted);
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stalls, or a long hold-off when one is requested.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            out_stall   <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Every result transaction is compared with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        meter_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_readings.size() == 0)
            begin
                $error("result transaction with no expectation pending");
                mismatch_count++;
            end
            else
            begin
                want = expected_readings.pop_front();
                check_field("download_percent", 64'(want.download_percent),
                            64'(download_percent));
                check_field("upload_percent", 64'(want.upload_percent),
                            64'(upload_percent));
                check_field("download_delta", 64'(want.download_delta),
                            64'(download_delta));
                check_field("upload_delta", 64'(want.upload_delta), 64'(upload_delta));
                check_field("download_rescale", 64'(want.download_rescale),
                            64'(download_rescale));
                check_field("download_rescale_valid", 64'(want.download_rescale_valid),
                            64'(download_rescale_valid));
                check_field("upload_rescale", 64'(want.upload_rescale),
                            64'(upload_rescale));
                check_field("upload_rescale_valid", 64'(want.upload_rescale_valid),
                            64'(upload_rescale_valid));
                check_field("redraw", 64'(want.redraw), 64'(redraw));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        snapshot_row_t plan [$];
        snapshot_row_t row;
        logic [COUNT_FIELD_W-1:0] rx_now;
        logic [COUNT_FIELD_W-1:0] tx_now;
        int width;
        int pick;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        kind           = KIND_BASELINE;
        query_ok       = QUERY_FAILED;
        received_count = '0;
        sent_count     = '0;
        base_count[DIR_RX] = '0;
        base_count[DIR_TX] = '0;
        peak_bytes[DIR_RX] = '0;
        peak_bytes[DIR_TX] = '0;
        rx_now = '0;
        tx_now = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table; comments give the model state the row runs into.
        // fresh reset, zero counters: zero deltas, nothing rises
        plan.push_back('{KIND_MEASURE, QUERY_OK, 64'd0, 64'd0, 1'b1, ALL_ZERO});
        // failed query, either kind: zeros and no state change
        plan.push_back('{KIND_MEASURE, QUERY_FAILED, ALL_ONES, ALL_ONES, 1'b1, ALL_ZERO});
        plan.push_back('{KIND_BASELINE, QUERY_FAILED, ALL_ONES, ALL_ONES, 1'b1, ALL_ZERO});
        // baseline capture gives zeros
        plan.push_back('{KIND_BASELINE, QUERY_OK, 64'd100, 64'd200, 1'b1, ALL_ZERO});
        // first measure: both peaks rise from zero
        plan.push_back('{KIND_MEASURE, QUERY_OK, 64'd1100, 64'd250, 1'b1, FIRST_RISE});
        // half the peak
        plan.push_back('{KIND_MEASURE, QUERY_OK, 64'd1600, 64'd275, 1'b0, ALL_ZERO});
        // rx went backwards, tx unchanged: zero deltas, 0 %
        plan.push_back('{KIND_MEASURE, QUERY_OK, 64'd1000, 64'd275, 1'b1, ALL_ZERO});
        // both peaks double: rescale one half
        plan.push_back('{KIND_MEASURE, QUERY_OK, 64'd3000, 64'd375, 1'b0, ALL_ZERO});
        // exactly the peak: 100 %, no rise
        plan.push_back('{KIND_MEASURE, QUERY_OK, 64'd5000, 64'd475, 1'b0, ALL_ZERO});
        // counters near the top of their range
        plan.push_back('{KIND_BASELINE, QUERY_OK, 64'hFFFF_FFFF_FFFF_FF00,
                         64'hFFFF_FFFF_FFFF_FFEF, 1'b1, ALL_ZERO});
        plan.push_back('{KIND_MEASURE, QUERY_OK, ALL_ONES, ALL_ONES, 1'b0, ALL_ZERO});
        // counter wrap reads as backwards
        plan.push_back('{KIND_MEASURE, QUERY_OK, 64'd0, 64'd0, 1'b1, ALL_ZERO});
        // difference above the delta window keeps its low bits only
        plan.push_back('{KIND_MEASURE, QUERY_OK, 64'h1_0000_0007, 64'h1_0000_0000,
                         1'b0, ALL_ZERO});
        plan.push_back('{KIND_BASELINE, QUERY_OK, 64'd0, 64'd0, 1'b1, ALL_ZERO});
        // rx rises above its peak, tx stays below
        plan.push_back('{KIND_MEASURE, QUERY_OK, 64'h0000_0100_0000_0BB8,
                         64'h8000_0000_0000_003C, 1'b0, ALL_ZERO});
        plan.push_back('{KIND_BASELINE, QUERY_OK, 64'h8000_0000_0000_0000, 64'd0,
                         1'b1, ALL_ZERO});
        // rx backwards across the top bit, tx equal to its peak
        plan.push_back('{KIND_MEASURE, QUERY_OK, 64'h7FFF_FFFF_FFFF_FFFF, 64'd100,
                         1'b0, ALL_ZERO});
        plan.push_back('{KIND_MEASURE, QUERY_FAILED, 64'h5555_5555_5555_5555,
                         64'hAAAA_AAAA_AAAA_AAAA, 1'b1, ALL_ZERO});
        plan.push_back('{KIND_MEASURE, QUERY_OK, 64'h7FFF_FFFF_FFFF_FFFF, 64'd100,
                         1'b0, ALL_ZERO});

        foreach (plan[i])
            offer_snapshot(plan[i]);
        rx_now = 64'h7FFF_FFFF_FFFF_FFFF;
        tx_now = 64'd100;

        // Random part. Mostly rising counters; the step width grows through
        // the run so the peaks keep rising until the end. Baselines, failed
        // queries and backward counters are mixed in.
        for (int idx = 0; idx < RANDOM_ITEMS; idx++)
        begin
            // idle phases: none, sender gaps, receiver stalls, both
            if (idx < RANDOM_ITEMS / 4)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else if (idx < RANDOM_ITEMS / 2)
            begin
                gap_pct   = 48;
                stall_pct = 0;
            end
            else if (idx < 3 * RANDOM_ITEMS / 4)
            begin
                gap_pct   = 0;
                stall_pct = 48;
            end
            else
            begin
                gap_pct   = 16;
                stall_pct = 16;
            end
            // long hold-off while the sender keeps offering
            if (idx == 10)
                hold_requests++;

            pick  = $urandom_range(0, 99);
            width = 1 + (idx * 32) / RANDOM_ITEMS;
            row = '0;
            row.kind = KIND_MEASURE;
            row.ok   = QUERY_OK;
            if (pick < 4)
            begin
                row.ok   = QUERY_FAILED;
                row.kind = 1'($urandom_range(0, 1));
                row.rx   = {$urandom, $urandom};
                row.tx   = {$urandom, $urandom};
            end
            else
            begin
                if (pick < 9)
                begin
                    row.kind = KIND_BASELINE;
                    rx_now = {$urandom, $urandom};
                    tx_now = {$urandom, $urandom};
                end
                else if (pick < 12)
                begin
                    rx_now = rx_now - 64'($urandom_range(1, 1000));
                    tx_now = {$urandom, $urandom};
                end
                else
                begin
                    rx_now = rx_now + (64'($urandom) & ((64'd1 << width) - 1));
                    tx_now = tx_now + (64'($urandom) & ((64'd1 << width) - 1));
                    // occasionally step past the delta window
                    if (pick < 16)
                        rx_now = rx_now + {32'($urandom_range(1, 3)), 32'd0};
                end
                row.rx = rx_now;
                row.tx = tx_now;
            end
            offer_snapshot(row);
        end

        // closing pair: the largest delta the window can hold
        row = '{KIND_BASELINE, QUERY_OK, 64'd0, 64'd0, 1'b0, ALL_ZERO};
        offer_snapshot(row);
        row = '{KIND_MEASURE, QUERY_OK, ALL_ONES, ALL_ONES, 1'b0, ALL_ZERO};
        offer_snapshot(row);

        @(negedge clk);
        in_valid <= 1'b0;
        gap_pct   = 0;
        stall_pct = 0;

        while (expected_readings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("traffic_rate_peak_meter: match");
        else
            $display("traffic_rate_peak_meter: mismatch");
        $finish;
    end

    // Timeout: ends a run that hangs and reports it as a mismatch
    initial
    begin
        #20_000_000;
        $display("traffic_rate_peak_meter: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
sv/trpm_pkg.sv
sv/trpm_serial_sub.sv
sv/trpm_divider.sv
sv/traffic_rate_peak_meter.sv
sv/trpm_checker.sv
test/traffic_rate_peak_meter_tb.sv
